/* rtl/pfpt_pkg.sv */
// pfpt_pkg: shared widths, codes and control structs of the frame phase tracker.
// No dependencies; used by the interfaces and all rtl modules.
package pfpt_pkg;

  localparam int TIME_W    = 48;
  localparam int PHASE_W   = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // bit of the action code that marks a query (codes four to seven)
  localparam int ACT_QUERY_BIT = 2;

  localparam logic [ACTION_W-1:0] ACT_SHIFT_PHASE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_PHASE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SHIFT_FREQ  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_FREQ    = 3'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TIME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECL_FREQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECL_PHASE = 2'd1;

  typedef struct packed {
    logic start;       // request accepted, load operands and search bounds
    logic search_step; // narrow search bounds from the read start time
    logic fetch;       // search settled, segment read issued
    logic latch;       // capture selected segment
    logic calc;        // register the offset product
    logic finish;      // commit table update and load result
  } pfpt_cmd_t;

  typedef struct packed {
    logic in_query;
    logic search_done;
    logic out_free;
  } pfpt_sts_t;

endpackage

/* rtl/pfpt_if.sv */
// pfpt_if: valid/ready channel interfaces for request, result and config.
// Depends on pfpt_pkg.
interface pfpt_in_if;
  logic                              valid;
  logic                              ready;
  logic [pfpt_pkg::ACTION_W-1:0]     action;
  logic [pfpt_pkg::TIME_W-1:0]       sample_time;
  logic [pfpt_pkg::PHASE_W-1:0]      operand_value;
  modport source (output valid, action, sample_time, operand_value, input ready);
  modport sink   (input valid, action, sample_time, operand_value, output ready);
endinterface

interface pfpt_out_if;
  logic                              valid;
  logic                              ready;
  logic [pfpt_pkg::STATUS_W-1:0]     status;
  logic [pfpt_pkg::PHASE_W-1:0]      frequency_word;
  logic [pfpt_pkg::PHASE_W-1:0]      accumulated_phase;
  logic [pfpt_pkg::PHASE_W-1:0]      offset_phase;
  modport source (output valid, status, frequency_word, accumulated_phase, offset_phase,
                  input ready);
  modport sink   (input valid, status, frequency_word, accumulated_phase, offset_phase,
                  output ready);
endinterface

interface pfpt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pfpt_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [pfpt_pkg::PHASE_W-1:0]      wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/pfpt_ctrl.sv */
// pfpt_ctrl: sequencing state machine of the frame phase tracker.
// Depends on pfpt_pkg; drives pfpt_dp through command/status structs.
module pfpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfpt_pkg::pfpt_sts_t sts,
  output pfpt_pkg::pfpt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SRCH_WAIT, S_FETCH_WAIT, S_CALC, S_FINISH
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd             = '0;
    cmd.start       = accept;
    cmd.search_step = (state_r == S_SRCH_WAIT);
    cmd.fetch       = (state_r == S_SRCH) && sts.search_done;
    cmd.latch       = (state_r == S_FETCH_WAIT);
    cmd.calc        = (state_r == S_CALC);
    cmd.finish      = (state_r == S_FINISH) && sts.out_free;
  end

  // ready stays low through reset and rises in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_SRCH;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_SRCH:       state_r <= sts.search_done ? S_FETCH_WAIT : S_SRCH_WAIT;
        S_SRCH_WAIT:  state_r <= S_SRCH;
        S_FETCH_WAIT: state_r <= S_CALC;
        S_CALC:       state_r <= S_FINISH;
        S_FINISH: if (sts.out_free) begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/pfpt_dp.sv */
// pfpt_dp: segment table memory, search bounds, offset arithmetic, result register.
// Depends on pfpt_pkg and the pfpt_if interfaces; sequenced by pfpt_ctrl.
module pfpt_dp #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  pfpt_in_if.sink             in_ch,
  pfpt_out_if.source          out_ch,
  pfpt_cfg_if.sink            cfg_ch,
  input  pfpt_pkg::pfpt_cmd_t cmd,
  output pfpt_pkg::pfpt_sts_t sts
);

  localparam int TW = pfpt_pkg::TIME_W;
  localparam int PW = pfpt_pkg::PHASE_W;
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = TW + 3 * PW;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SEGMENTS);

  // entry layout: {start, frequency, phase total, offset}
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [pfpt_pkg::ACTION_W-1:0] action_r;
  logic [TW-1:0] time_r;
  logic [PW-1:0] operand_r;
  logic [CW-1:0] lo_r, hi_r, count_r;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          base_r;
  logic [TW-1:0] seg_start_r;
  logic [PW-1:0] seg_freq_r, seg_phase_r, seg_off_r;
  logic [PW-1:0] decl_freq_r, decl_phase_r;
  logic [PW-1:0] prod_r;
  logic [2*PW-1:0] prod_full;
  logic [PW-1:0] diff, dt;
  logic          is_query;

  logic                          out_valid_r;
  logic [pfpt_pkg::STATUS_W-1:0] out_status_r, status_nxt;
  logic [PW-1:0] out_freq_r, out_phase_r, out_off_r;
  logic [PW-1:0] freq_nxt, phase_nxt, off_nxt;

  assign is_query = action_r[pfpt_pkg::ACT_QUERY_BIT];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign rd_addr  = (lo_r >= hi_r) ? AW'(lo_r - CW'(1)) : mid[AW-1:0];

  assign sts.in_query    = in_ch.action[pfpt_pkg::ACT_QUERY_BIT];
  assign sts.search_done = (lo_r >= hi_r);
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  // config port, ready whenever out of reset
  assign cfg_ch.ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_freq_r  <= '0;
      decl_phase_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        pfpt_pkg::CFG_DECL_FREQ:  decl_freq_r  <= cfg_ch.wr_data;
        pfpt_pkg::CFG_DECL_PHASE: decl_phase_r <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // segment table
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) mem[count_r[AW-1:0]] <= {time_r, freq_nxt, phase_nxt, off_nxt};
  end

  // request capture and search bounds; an op starts already settled on the last segment
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r  <= in_ch.action;
      time_r    <= in_ch.sample_time;
      operand_r <= in_ch.operand_value;
      lo_r      <= sts.in_query ? '0 : count_r;
      hi_r      <= count_r;
    end else if (cmd.search_step) begin
      if (rdata_r[EW-1 -: TW] <= time_r) lo_r <= mid + CW'(1);
      else                               hi_r <= mid;
    end
    if (cmd.fetch) base_r <= (lo_r == '0);
    if (cmd.latch) begin
      seg_start_r <= base_r ? '0           : rdata_r[EW-1 -: TW];
      seg_freq_r  <= base_r ? decl_freq_r  : rdata_r[3*PW-1 -: PW];
      seg_phase_r <= base_r ? decl_phase_r : rdata_r[2*PW-1 -: PW];
      seg_off_r   <= base_r ? '0           : rdata_r[PW-1:0];
    end
    if (cmd.calc) prod_r <= prod_full[PW-1:0];
  end

  assign diff      = seg_freq_r - decl_freq_r;
  assign dt        = time_r[PW-1:0] - seg_start_r[PW-1:0];
  assign prod_full = diff * dt;

  always_comb begin
    status_nxt = pfpt_pkg::ST_OK;
    freq_nxt   = seg_freq_r;
    phase_nxt  = seg_phase_r;
    off_nxt    = seg_off_r + prod_r;
    wr_en      = 1'b0;
    if (!is_query) begin
      if (time_r < seg_start_r || count_r == FULL_CNT) begin
        status_nxt = (time_r < seg_start_r) ? pfpt_pkg::ST_BAD_TIME : pfpt_pkg::ST_FULL;
        freq_nxt   = '0;
        phase_nxt  = '0;
        off_nxt    = '0;
      end else begin
        wr_en = cmd.finish;
        case (action_r)
          pfpt_pkg::ACT_SHIFT_PHASE: phase_nxt = seg_phase_r + operand_r;
          pfpt_pkg::ACT_SET_PHASE:   phase_nxt = operand_r;
          pfpt_pkg::ACT_SHIFT_FREQ:  freq_nxt  = seg_freq_r + operand_r;
          pfpt_pkg::ACT_SET_FREQ:    freq_nxt  = operand_r;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) count_r <= count_r + CW'(1);
      if (cmd.finish)        out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_freq_r   <= freq_nxt;
      out_phase_r  <= phase_nxt;
      out_off_r    <= off_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.frequency_word    = out_freq_r;
  assign out_ch.accumulated_phase = out_phase_r;
  assign out_ch.offset_phase      = out_off_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("segment count past table size");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == $past(count_r) + CW'(1))
    else $error("segment count moved by other than one");
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_step |-> lo_r < hi_r) else $error("search step with empty range");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish)) else $error("result without finish");

endmodule

/* rtl/pulse_frame_phase_tracker_unit.sv */
// pulse_frame_phase_tracker_unit: top level of the frame phase tracker.
// Depends on pfpt_pkg, pfpt_if, pfpt_ctrl and pfpt_dp.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   action, sample_time, operand_value
//  out_ch   out  valid/ready   status, frequency_word, accumulated_phase, offset_phase
//  cfg_ch   in   valid/ready   reg_index, wr_data (ready whenever out of reset)
//
// Sequence: an op goes from accept straight to segment fetch, offset product and commit;
//   a query first runs up to log2(MAX_SEGMENTS)+1 binary-search probes of the segment
//   memory, each waiting on the registered memory read.
// One request in flight; the next is accepted once its result sits in the output register.
// Reset (rst_n low, synchronous) empties the segment table and clears the declared values;
//   in_ch.ready rises in the cycle after reset is released.
// A stalled result holds the datapath in its final step until out_ch.ready frees the slot.
module pulse_frame_phase_tracker_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pfpt_in_if.sink     in_ch,
  pfpt_out_if.source  out_ch,
  pfpt_cfg_if.sink    cfg_ch
);

  pfpt_pkg::pfpt_cmd_t cmd;   // controller -> datapath strobes
  pfpt_pkg::pfpt_sts_t sts;   // datapath -> controller flags
  logic                in_ready;

  assign in_ch.ready = in_ready;

  // state machine: idle, search probes, segment fetch, multiply, commit
  pfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // segment table, offset accrual and result register
  pfpt_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
